// File: design/btlpm_pkg.sv
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared types and constants for the binary-trie longest-prefix-match block.
// ----------------------------------------------------------------------------
`default_nettype none

package btlpm_pkg;

  localparam int NODE_COUNT_DEF = 1024;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int PREFIX_W = 32;
  localparam int LEN_W    = 6;
  localparam int ROUTER_W = 8;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } walk_state_e;

endpackage

`default_nettype wire

// File: design/btlpm_node_mem.sv
// ----------------------------------------------------------------------------
// btlpm_node_mem
// Trie node store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btlpm_node_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 28
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/binary_trie_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// Router table as a binary trie: insert prefixes, look up longest match.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on the s_axis channel. tuser selects insert (0)
//   or lookup (1); tdata carries the address or prefix, its length and the
//   router number. Each input transaction yields one output transaction on
//   m_axis with match flag, router and insert status.
//   The trie walk visits one level per cycle through a single node memory
//   port; an item's prefix length is saturated to ADDR_BITS. The next item
//   is accepted only after the walker has passed the result of the last one
//   to the output register. A walk ends early when a lookup finds no child
//   or an insert runs out of nodes.
//   s_axis_tready is high only while the walker is idle. A finished result
//   waits in the output register while the next item is accepted and walked;
//   the walker holds in its final state until the output register is free.
//   Reset empties the trie at once: the root lives in flip-flops and every
//   other node entry is written when it is allocated, so no clearing pass
//   is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_longest_prefix_match
  import btlpm_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [31:0] prefix_bits, [37:32] prefix_len, [45:38] router_in, [47:46] zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [0] match_found, [8:1] router_out, [9] status, [15:10] zero
  output logic      [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FREE_W = $clog2(NODE_COUNT + 1);
  localparam int CNT_W  = $clog2(ADDR_BITS + 1);
  localparam int EXT_W  = (ADDR_BITS > PREFIX_W) ? ADDR_BITS : PREFIX_W;
  localparam int ENT_W  = 2 * NODE_W + 1 + ROUTER_W;
  localparam int MARK_B = ROUTER_W;
  localparam int C0_LO  = ROUTER_W + 1;
  localparam int C1_LO  = ROUTER_W + 1 + NODE_W;

  walk_state_e state_q, state_d;

  logic [ADDR_BITS-1:0] shift_q, shift_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 kind_q, kind_d;
  logic [ROUTER_W-1:0]  router_q, router_d;
  logic [NODE_W-1:0]    node_q, node_d;
  logic                 fresh_q, fresh_d;
  logic [FREE_W-1:0]    free_q, free_d;
  logic                 found_q, found_d;
  logic [ROUTER_W-1:0]  best_q, best_d;
  logic                 status_q, status_d;

  logic [NODE_W-1:0]    root_c0_q, root_c0_d;
  logic [NODE_W-1:0]    root_c1_q, root_c1_d;
  logic                 root_mark_q, root_mark_d;
  logic [ROUTER_W-1:0]  root_router_q, root_router_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_match_q, out_match_d;
  logic [ROUTER_W-1:0]  out_router_q, out_router_d;
  logic                 out_status_q, out_status_d;

  logic                 mem_we;
  logic [NODE_W-1:0]    mem_waddr;
  logic [ENT_W-1:0]     mem_wdata;
  logic [ENT_W-1:0]     mem_rdata;

  logic [EXT_W-1:0]     addr_ext;
  logic [LEN_W-1:0]     in_len;
  logic                 at_root;
  logic [NODE_W-1:0]    ent_c0, ent_c1, child_w;
  logic                 ent_mark;
  logic [ROUTER_W-1:0]  ent_router;
  logic                 bit_w;
  logic                 pool_full;
  logic                 walk_end;
  logic                 out_free;

  btlpm_node_mem #(
    .DEPTH(NODE_COUNT),
    .WIDTH(ENT_W)
  ) u_node_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(node_d),
    .rdata_o(mem_rdata)
  );

  assign addr_ext = EXT_W'(s_axis_tdata[PREFIX_W-1:0]);
  assign in_len   = s_axis_tdata[PREFIX_W +: LEN_W];

  // Current node entry: root from flip-flops, a just-allocated node is empty.
  assign at_root = (node_q == '0);
  always_comb begin
    if (at_root) begin
      ent_c0     = root_c0_q;
      ent_c1     = root_c1_q;
      ent_mark   = root_mark_q;
      ent_router = root_router_q;
    end else if (fresh_q) begin
      ent_c0     = '0;
      ent_c1     = '0;
      ent_mark   = 1'b0;
      ent_router = '0;
    end else begin
      ent_c0     = mem_rdata[C0_LO +: NODE_W];
      ent_c1     = mem_rdata[C1_LO +: NODE_W];
      ent_mark   = mem_rdata[MARK_B];
      ent_router = mem_rdata[ROUTER_W-1:0];
    end
  end

  assign bit_w     = shift_q[ADDR_BITS-1];
  assign child_w   = bit_w ? ent_c1 : ent_c0;
  assign pool_full = (free_q == FREE_W'(NODE_COUNT));
  assign out_free  = !out_valid_q || m_axis_tready;

  always_comb begin
    if (cnt_q == '0) begin
      walk_end = 1'b1;
    end else if (child_w != '0) begin
      walk_end = 1'b0;
    end else if (kind_q == KIND_LOOKUP) begin
      walk_end = 1'b1;
    end else begin
      walk_end = pool_full;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = M_TDATA_W'({out_status_q, out_router_q, out_match_q});
  end

  // Datapath
  always_comb begin
    shift_d       = shift_q;
    cnt_d         = cnt_q;
    kind_d        = kind_q;
    router_d      = router_q;
    node_d        = node_q;
    fresh_d       = fresh_q;
    free_d        = free_q;
    found_d       = found_q;
    best_d        = best_q;
    status_d      = status_q;
    root_c0_d     = root_c0_q;
    root_c1_d     = root_c1_q;
    root_mark_d   = root_mark_q;
    root_router_d = root_router_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_match_d   = out_match_q;
    out_router_d  = out_router_q;
    out_status_d  = out_status_q;
    mem_we        = 1'b0;
    mem_waddr     = node_q;
    mem_wdata     = {ent_c1, ent_c0, ent_mark, ent_router};

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          shift_d  = addr_ext[ADDR_BITS-1:0];
          if (32'(in_len) > ADDR_BITS) begin
            cnt_d = CNT_W'(ADDR_BITS);
          end else begin
            cnt_d = CNT_W'(in_len);
          end
          kind_d   = s_axis_tuser;
          router_d = s_axis_tdata[PREFIX_W+LEN_W +: ROUTER_W];
          node_d   = '0;
          fresh_d  = 1'b0;
          found_d  = 1'b0;
          best_d   = '0;
          status_d = STATUS_OK;
        end
      end

      ST_WALK: begin
        if (kind_q == KIND_LOOKUP) begin
          // Keep the deepest marked node seen so far.
          if (ent_mark) begin
            found_d = 1'b1;
            best_d  = ent_router;
          end
          if (!walk_end) begin
            node_d  = child_w;
            cnt_d   = cnt_q - 1'b1;
            shift_d = shift_q << 1;
          end
        end else if (cnt_q == '0) begin
          // Mark the final node of the prefix.
          if (at_root) begin
            root_mark_d   = 1'b1;
            root_router_d = router_q;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {ent_c1, ent_c0, 1'b1, router_q};
          end
        end else if (child_w != '0) begin
          node_d  = child_w;
          fresh_d = 1'b0;
          cnt_d   = cnt_q - 1'b1;
          shift_d = shift_q << 1;
        end else if (pool_full) begin
          status_d = STATUS_FULL;
          // A node allocated on this walk is linked already: give it its empty entry.
          if (fresh_q && !at_root) begin
            mem_we    = 1'b1;
            mem_wdata = '0;
          end
        end else begin
          // Allocate the next free node and link it under the current one.
          if (at_root) begin
            if (bit_w) begin
              root_c1_d = free_q[NODE_W-1:0];
            end else begin
              root_c0_d = free_q[NODE_W-1:0];
            end
          end else begin
            mem_we = 1'b1;
            if (bit_w) begin
              mem_wdata = {free_q[NODE_W-1:0], ent_c0, ent_mark, ent_router};
            end else begin
              mem_wdata = {ent_c1, free_q[NODE_W-1:0], ent_mark, ent_router};
            end
          end
          node_d  = free_q[NODE_W-1:0];
          fresh_d = 1'b1;
          free_d  = free_q + 1'b1;
          cnt_d   = cnt_q - 1'b1;
          shift_d = shift_q << 1;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_match_d  = found_q;
          out_router_d = best_q;
          out_status_d = status_q;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_q      <= '0;
      fresh_q     <= 1'b0;
      free_q      <= FREE_W'(1);
      root_c0_q   <= '0;
      root_c1_q   <= '0;
      root_mark_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      fresh_q     <= fresh_d;
      free_q      <= free_d;
      root_c0_q   <= root_c0_d;
      root_c1_q   <= root_c1_d;
      root_mark_q <= root_mark_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q       <= shift_d;
    cnt_q         <= cnt_d;
    kind_q        <= kind_d;
    router_q      <= router_d;
    found_q       <= found_d;
    best_q        <= best_d;
    status_q      <= status_d;
    root_router_q <= root_router_d;
    out_match_q   <= out_match_d;
    out_router_q  <= out_router_d;
    out_status_q  <= out_status_d;
  end

endmodule

`default_nettype wire

// File: dv/binary_trie_longest_prefix_match_tb.sv
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match_tb
// Self-checking bench for the trie router table. Prefix inserts and address
// lookups are streamed in, with idle bursts on both sides. A trie copy kept
// in the bench predicts every result, and the results are checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_trie_longest_prefix_match_tb
  import btlpm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_OPS  = 1150;
  localparam int CALM_OPS    = 120;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    logic                kind;
    logic [PREFIX_W-1:0] bits;
    logic [LEN_W-1:0]    len;
    logic [ROUTER_W-1:0] router;
  } route_op_t;

  typedef struct packed {
    logic                match_found;
    logic [ROUTER_W-1:0] router;
    logic                status;
  } route_result_t;

  typedef struct packed {
    logic [PREFIX_W-1:0] bits;
    logic [LEN_W-1:0]    len;
  } prefix_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = KIND_INSERT;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  binary_trie_longest_prefix_match DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  route_op_t     pending_ops[$];
  route_result_t route_expected[$];
  prefix_t       known_prefixes[$];

  // shadow trie
  int unsigned trie_zero[NODE_COUNT_DEF];
  int unsigned trie_one[NODE_COUNT_DEF];
  bit          trie_marked[NODE_COUNT_DEF];
  logic [7:0]  trie_router[NODE_COUNT_DEF];
  int unsigned trie_next_free = 1;

  int          err_count   = 0;
  int          quiet_count = 0;
  int          send_gap    = 0;
  int          hold_gap    = 0;
  int unsigned sent_count  = 0;
  int unsigned taken_count = 0;
  bit          calm_tail   = 1'b0;

  initial begin
    trie_zero[0]   = 0;
    trie_one[0]    = 0;
    trie_marked[0] = 1'b0;
  end

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Walk the shadow trie for one transaction and return the result it yields.
  function automatic route_result_t trie_walk(input route_op_t op);
    int unsigned   depth;
    int unsigned   node;
    int unsigned   child;
    logic          b;
    route_result_t res;
    depth = (op.len > ADDR_BITS_DEF) ? ADDR_BITS_DEF : op.len;
    node  = 0;
    res   = '0;
    if (op.kind == KIND_INSERT) begin
      res.status = STATUS_OK;
      for (int i = 0; i < depth; i++) begin
        b     = op.bits[ADDR_BITS_DEF-1-i];
        child = b ? trie_one[node] : trie_zero[node];
        if (child == 0) begin
          if (trie_next_free >= NODE_COUNT_DEF) begin
            res.status = STATUS_FULL;
            break;
          end
          child = trie_next_free;
          trie_next_free++;
          trie_zero[child]   = 0;
          trie_one[child]    = 0;
          trie_marked[child] = 1'b0;
          if (b) trie_one[node] = child;
          else   trie_zero[node] = child;
        end
        node = child;
      end
      if (res.status == STATUS_OK) begin
        trie_marked[node] = 1'b1;
        trie_router[node] = op.router;
      end
    end else begin
      res.status = STATUS_OK;
      if (trie_marked[0]) begin
        res.match_found = 1'b1;
        res.router      = trie_router[0];
      end
      for (int i = 0; i < depth; i++) begin
        b     = op.bits[ADDR_BITS_DEF-1-i];
        child = b ? trie_one[node] : trie_zero[node];
        if (child == 0) break;
        node = child;
        if (trie_marked[node]) begin
          res.match_found = 1'b1;
          res.router      = trie_router[node];
        end
      end
    end
    return res;
  endfunction

  task automatic queue_op(input logic kind, input logic [31:0] bits, input int len,
                          input logic [7:0] router);
    route_op_t op;
    prefix_t   pfx;
    op.kind   = kind;
    op.bits   = bits;
    op.len    = len[LEN_W-1:0];
    op.router = router;
    pfx.bits  = bits;
    pfx.len   = len[LEN_W-1:0];
    pending_ops = {pending_ops, op};
    if (kind == KIND_INSERT) known_prefixes = {known_prefixes, pfx};
  endtask

  function automatic int pick_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return $urandom_range(0, 12);
    if (sel < 90) return $urandom_range(13, 32);
    return $urandom_range(33, 63);
  endfunction

  // Stimulus and end of run
  initial begin : stim
    int          sel;
    int          len;
    prefix_t     p;
    logic [31:0] keep_mask;
    logic [31:0] addr;

    // directed
    queue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32, 8'h00);  // empty table
    queue_op(KIND_INSERT, 32'h0000_0000, 0, 8'h07);   // default route at root
    queue_op(KIND_LOOKUP, 32'h89AB_CDEF, 0, 8'h00);
    queue_op(KIND_INSERT, 32'h8000_0000, 1, 8'h01);
    queue_op(KIND_INSERT, 32'hFFFF_FFFF, 32, 8'hFF);
    queue_op(KIND_INSERT, 32'h0000_0000, 32, 8'h00);
    queue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32, 8'h00);
    queue_op(KIND_LOOKUP, 32'hFFFF_FFFE, 32, 8'h00);  // deep path, shallow mark wins
    queue_op(KIND_LOOKUP, 32'h0000_0000, 63, 8'h00);  // saturated length
    queue_op(KIND_INSERT, 32'hFFFF_FFFF, 63, 8'hAA);  // overwrite via saturated length
    queue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 40, 8'h00);
    queue_op(KIND_INSERT, 32'hC000_0000, 2, 8'h55);
    queue_op(KIND_LOOKUP, 32'hC0FF_FFFF, 8, 8'h00);
    queue_op(KIND_LOOKUP, 32'h4000_0000, 32, 8'h00);  // missing child ends walk
    queue_op(KIND_INSERT, 32'h1234_5678, 16, 8'h3C);
    queue_op(KIND_LOOKUP, 32'h1234_FFFF, 16, 8'h00);
    queue_op(KIND_LOOKUP, 32'h1234_5678, 15, 8'h00);
    queue_op(KIND_INSERT, 32'h1234_5678, 16, 8'hC3);  // reinsert
    queue_op(KIND_LOOKUP, 32'h1234_0000, 33, 8'h00);

    // random: pool fills partway through, later inserts report full
    for (int n = 0; n < RANDOM_OPS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        if ($urandom_range(0, 4) == 0) begin
          p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
          queue_op(KIND_INSERT, p.bits, int'(p.len), 8'($urandom_range(0, 255)));
        end else begin
          queue_op(KIND_INSERT, $urandom, pick_len(), 8'($urandom_range(0, 255)));
        end
      end else if (sel < 85) begin
        // address under a stored prefix, random tail
        p         = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
        len       = (p.len > 32) ? 32 : int'(p.len);
        keep_mask = (len == 0) ? 32'h0 : ~(32'hFFFF_FFFF >> len);
        addr      = (p.bits & keep_mask) | ($urandom & ~keep_mask);
        len       = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 63)
                                                : $urandom_range(len, 32);
        queue_op(KIND_LOOKUP, addr, len, 8'($urandom_range(0, 255)));
      end else begin
        queue_op(KIND_LOOKUP, $urandom, $urandom_range(0, 63),
                 8'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || s_axis_tvalid || route_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Input driver
  always @(negedge clk_i) begin : drv
    route_op_t op;
    if (rst_ni) begin
      calm_tail = (pending_ops.size() < CALM_OPS);
      // Advance once the transaction on the bus has been taken.
      if (!s_axis_tvalid || taken_count == sent_count) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops.pop_front();
          s_axis_tdata  <= {2'b00, op.router, op.len, op.bits};
          s_axis_tuser  <= op.kind;
          s_axis_tvalid <= 1'b1;
          sent_count++;
          if (!calm_tail && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 10);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output backpressure
  always @(negedge clk_i) begin : sink
    if (rst_ni) begin
      if (hold_gap > 0) begin
        hold_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm_tail && $urandom_range(0, 5) == 0) hold_gap = $urandom_range(1, 10);
      end
    end
  end

  // Monitor, checker and watchdog
  always @(posedge clk_i) begin : mon
    route_op_t     op;
    route_result_t want;
    route_result_t got;
    if (rst_ni) begin
      quiet_count++;
      if (s_axis_tvalid && s_axis_tready) begin
        op.kind   = s_axis_tuser;
        op.bits   = s_axis_tdata[31:0];
        op.len    = s_axis_tdata[37:32];
        op.router = s_axis_tdata[45:38];
        want      = trie_walk(op);
        route_expected = {route_expected, want};
        taken_count++;
        quiet_count = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_count     = 0;
        got.match_found = m_axis_tdata[0];
        got.router      = m_axis_tdata[8:1];
        got.status      = m_axis_tdata[9];
        if (route_expected.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result transaction, actual %h", $time, m_axis_tdata);
        end else begin
          want = route_expected.pop_front();
          if (got.match_found !== want.match_found) begin
            err_count++;
            $display("%0t: match_found mismatch, expected %0d actual %0d", $time,
                     want.match_found, got.match_found);
          end
          if (got.router !== want.router) begin
            err_count++;
            $display("%0t: router_out mismatch, expected %0d actual %0d", $time,
                     want.router, got.router);
          end
          if (got.status !== want.status) begin
            err_count++;
            $display("%0t: status mismatch, expected %0d actual %0d", $time,
                     want.status, got.status);
          end
        end
      end
      if (quiet_count >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, route_expected.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
